@@ sv/dtt_pkg.sv @@
// Shared types, codes and helpers for the deadline timer table.
package dtt_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_REM   = 2'd1;
  localparam logic [1:0] OP_SCHED = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int US_PER_MS   = 1000;
  localparam int MUL_STEPS   = 4;
  localparam int MULC_W      = $clog2(MUL_STEPS + 1);

  // x / 1000 == (x * MS_RECIP) >> MS_SHIFT for every 48-bit x, with
  // MS_RECIP = ceil(2^58 / 1000), a 49-bit constant.
  localparam int          MS_SHIFT = 58;
  localparam logic [48:0] MS_RECIP =
    49'((64'd1 << MS_SHIFT) / 64'(US_PER_MS) + 64'd1);

  localparam logic [47:0] DEADLINE_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [47:0] deadline;
    logic [31:0] period;
    logic        periodic;
    logic [31:0] ident;
  } slot_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic emit;
    logic emit_pend;
    logic emit_last;
    logic div_start;
    logic take;
    logic rearm1;
    logic rearm2;
  } dtt_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       scan_done;
    logic       found;
    logic       overdue;
    logic       div_done;
    logic       out_free;
    logic       pend_v;
    logic       cnt_full;
    logic       best_periodic;
  } dtt_sts_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? DEADLINE_MAX : s[47:0];
  endfunction

endpackage

@@ sv/dtt_if.sv @@
// Valid/ready channel interfaces for the timer table's items and results.
interface dtt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [47:0] now_us;
  logic [31:0] delay_us;
  logic        periodic;
  logic [31:0] target_id;
  modport source(output valid, opcode, now_us, delay_us, periodic, target_id, input ready);
  modport sink(input valid, opcode, now_us, delay_us, periodic, target_id, output ready);
endinterface

interface dtt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        timer_ident;
  logic signed [39:0] wait_ms;
  logic               last;
  modport source(output valid, status, timer_ident, wait_ms, last, input ready);
  modport sink(input valid, status, timer_ident, wait_ms, last, output ready);
endinterface

@@ sv/dtt_ctrl.sv @@
// Sequencer that steps the timer table through scans, updates and results.
module dtt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dtt_pkg::dtt_sts_t sts,
  output dtt_pkg::dtt_cmd_t cmd
);
  import dtt_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_EMIT   = 4'd4;
  localparam logic [3:0] S_PMID   = 4'd5;
  localparam logic [3:0] S_TAKE   = 4'd6;
  localparam logic [3:0] S_RARM1  = 4'd7;
  localparam logic [3:0] S_RARM2  = 4'd8;
  localparam logic [3:0] S_NEXT   = 4'd9;
  localparam logic [3:0] S_PLAST  = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: if (sts.scan_done) state_nxt = S_DECIDE;
      S_DECIDE: begin
        unique case (sts.op) inside
          OP_ADD, OP_REM: state_nxt = S_EMIT;
          OP_QUERY: begin
            if (sts.found && !sts.overdue) begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          default: begin
            if (sts.found) state_nxt = sts.pend_v ? S_PMID : S_TAKE;
            else           state_nxt = sts.pend_v ? S_PLAST : S_EMIT;
          end
        endcase
      end
      S_DIV: if (sts.div_done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PMID: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_pend = 1'b1;
          state_nxt     = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = sts.best_periodic ? S_RARM1 : S_NEXT;
      end
      S_RARM1: begin
        cmd.rearm1 = 1'b1;
        state_nxt  = S_RARM2;
      end
      S_RARM2: begin
        cmd.rearm2 = 1'b1;
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        if (sts.cnt_full) begin
          state_nxt = S_PLAST;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_PLAST: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_pend = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free) else $error("result loaded into a full output register");
  // A timer is only fired after a scan found one.
  a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> sts.found) else $error("fire without a selected timer");
  // The millisecond divide runs only for a future deadline.
  a_div_future: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (sts.found && !sts.overdue)) else $error("divide on bad deadline");

endmodule

@@ sv/dtt_dp.sv @@
// Datapath: slot memory, scan compare, re-arm adders, reciprocal multiplier and output register.
module dtt_dp #(
  parameter int N = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_opcode,
  input  logic [47:0]        in_now_us,
  input  logic [31:0]        in_delay_us,
  input  logic               in_periodic,
  input  logic [31:0]        in_target_id,
  input  dtt_pkg::dtt_cmd_t  cmd,
  output dtt_pkg::dtt_sts_t  sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [31:0]        out_timer_ident,
  output logic signed [39:0] out_wait_ms,
  output logic               out_last
);
  import dtt_pkg::*;

  localparam int IW = (N > 1) ? $clog2(N) : 1;

  slot_t mem [N];
  slot_t mem_q;

  logic [N-1:0]  valid_r, picked_r;
  logic [31:0]   next_id_r;
  logic [1:0]    op_r;
  logic [47:0]   now_r;
  logic [31:0]   delay_r, target_r;
  logic          per_r;

  logic          scan_act_r, rd_vld_r;
  logic [IW-1:0] addr_r, rd_idx_r;
  logic          found_r;
  logic [IW-1:0] best_idx_r;
  logic [47:0]   best_dl_r;
  logic [31:0]   best_per_r, best_id_r;
  logic          best_pf_r;

  logic          pend_v_r;
  logic [31:0]   pend_id_r;
  logic [CNT_W-1:0] cnt_r;
  logic [47:0]   sum1_r;

  logic              div_busy_r;
  logic [MULC_W-1:0] div_cnt_r;
  logic [47:0]       q_r;
  logic [96:0]       prod_r;

  logic               ov_r;
  logic [1:0]         ost_r;
  logic [31:0]        oid_r;
  logic signed [39:0] owait_r;
  logic               olast_r;

  logic          hit, ev_valid, out_free, overdue;
  logic [23:0]   mul_a;
  logic [24:0]   mul_b;
  logic [48:0]   mul_p;
  logic [96:0]   mul_term;
  logic [47:0]   rearm_dl;
  logic [1:0]         s_status;
  logic [31:0]        s_ident;
  logic signed [39:0] s_wait;

  assign ev_valid = valid_r[rd_idx_r];
  assign overdue  = best_dl_r < now_r;
  assign out_free = !ov_r || out_ready;
  assign rearm_dl = (now_r > sum1_r) ? sat_add48(now_r, best_per_r) : sum1_r;

  // The 48 by 49 bit product is built from four 24 by 25 bit partial products,
  // one per cycle, low halves first.
  always_comb begin
    mul_a = q_r[23:0];
    mul_b = MS_RECIP[24:0];
    case (div_cnt_r)
      MULC_W'(1): begin
        mul_a = q_r[47:24];
        mul_b = MS_RECIP[24:0];
      end
      MULC_W'(2): begin
        mul_a = q_r[23:0];
        mul_b = {1'b0, MS_RECIP[48:25]};
      end
      MULC_W'(3): begin
        mul_a = q_r[47:24];
        mul_b = {1'b0, MS_RECIP[48:25]};
      end
      default: ;
    endcase
    mul_p = {25'd0, mul_a} * {24'd0, mul_b};
    case (div_cnt_r)
      MULC_W'(1): mul_term = {24'd0, mul_p, 24'd0};
      MULC_W'(2): mul_term = {23'd0, mul_p, 25'd0};
      MULC_W'(3): mul_term = {mul_p[47:0], 49'd0};
      default:    mul_term = {48'd0, mul_p};
    endcase
  end

  always_comb begin
    hit = 1'b0;
    case (op_r)
      OP_ADD: hit = !ev_valid && !found_r;
      OP_REM: hit = ev_valid && (mem_q.ident == target_r) && !found_r;
      OP_QUERY: hit = ev_valid && (!found_r || mem_q.deadline < best_dl_r);
      default: hit = ev_valid && !picked_r[rd_idx_r] && (mem_q.deadline < now_r) &&
                     (!found_r || mem_q.deadline < best_dl_r);
    endcase
  end

  always_comb begin
    s_status = ST_OK;
    s_ident  = '0;
    s_wait   = '0;
    case (op_r)
      OP_ADD: begin
        s_status = found_r ? ST_OK : ST_FULL;
        s_ident  = found_r ? next_id_r : '0;
      end
      OP_REM: s_status = found_r ? ST_OK : ST_NOTFOUND;
      OP_SCHED: s_status = ST_NONE;
      default: s_wait = !found_r ? '1 :
                        (overdue ? '0 : $signed({1'b0, prod_r[96:MS_SHIFT]}));
    endcase
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (scan_act_r) mem_q <= mem[addr_r];
    if (cmd.emit && !cmd.emit_pend && op_r == OP_ADD && found_r)
      mem[best_idx_r] <= '{deadline: sat_add48(now_r, delay_r),
                           period: per_r ? delay_r : 32'd0,
                           periodic: per_r, ident: next_id_r};
    else if (cmd.rearm2)
      mem[best_idx_r] <= '{deadline: rearm_dl, period: best_per_r,
                           periodic: 1'b1, ident: best_id_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      now_r    <= in_now_us;
      delay_r  <= in_delay_us;
      per_r    <= in_periodic;
      target_r <= in_target_id;
    end
    if (rd_vld_r && hit) begin
      best_idx_r <= rd_idx_r;
      best_dl_r  <= mem_q.deadline;
      best_per_r <= mem_q.period;
      best_pf_r  <= mem_q.periodic;
      best_id_r  <= mem_q.ident;
    end
    if (cmd.take) pend_id_r <= best_id_r;
    if (cmd.rearm1) sum1_r <= sat_add48(best_dl_r, best_per_r);
    rd_idx_r <= addr_r;
    if (cmd.div_start) begin
      q_r    <= best_dl_r - now_r;
      prod_r <= '0;
    end else if (div_busy_r) begin
      prod_r <= prod_r + mul_term;
    end
    if (cmd.emit) begin
      ost_r   <= cmd.emit_pend ? ST_OK : s_status;
      oid_r   <= cmd.emit_pend ? pend_id_r : s_ident;
      owait_r <= cmd.emit_pend ? '0 : s_wait;
      olast_r <= cmd.emit_pend ? cmd.emit_last : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      picked_r   <= '0;
      next_id_r  <= '0;
      scan_act_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      addr_r     <= '0;
      found_r    <= 1'b0;
      pend_v_r   <= 1'b0;
      cnt_r      <= '0;
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
      ov_r       <= 1'b0;
    end else begin
      rd_vld_r <= scan_act_r;
      if (cmd.scan_start) begin
        scan_act_r <= 1'b1;
        addr_r     <= '0;
        found_r    <= 1'b0;
      end else if (scan_act_r) begin
        if (addr_r == IW'(N - 1)) scan_act_r <= 1'b0;
        else                      addr_r     <= addr_r + IW'(1);
      end
      if (rd_vld_r && hit) found_r <= 1'b1;
      if (cmd.load) begin
        picked_r <= '0;
        pend_v_r <= 1'b0;
        cnt_r    <= '0;
      end
      if (cmd.emit && !cmd.emit_pend && found_r) begin
        if (op_r == OP_ADD) begin
          valid_r[best_idx_r] <= 1'b1;
          next_id_r           <= next_id_r + 32'd1;
        end else if (op_r == OP_REM) begin
          valid_r[best_idx_r] <= 1'b0;
        end
      end
      if (cmd.take) begin
        picked_r[best_idx_r] <= 1'b1;
        pend_v_r             <= 1'b1;
        cnt_r                <= cnt_r + CNT_W'(1);
        if (!best_pf_r) valid_r[best_idx_r] <= 1'b0;
      end
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + MULC_W'(1);
        if (div_cnt_r == MULC_W'(MUL_STEPS - 1)) div_busy_r <= 1'b0;
      end
      if (cmd.emit)     ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_comb begin
    sts.op            = op_r;
    sts.scan_done     = !scan_act_r && !rd_vld_r;
    sts.found         = found_r;
    sts.overdue       = overdue;
    sts.div_done      = !div_busy_r;
    sts.out_free      = out_free;
    sts.pend_v        = pend_v_r;
    sts.cnt_full      = cnt_r == CNT_W'(MAX_RESULTS);
    sts.best_periodic = best_pf_r;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_timer_ident = oid_r;
  assign out_wait_ms     = owait_r;
  assign out_last        = olast_r;

endmodule

@@ sv/deadline_timer_table.sv @@
// Top level of the deadline timer table: sequencer plus datapath.
//
// The block holds up to TIMER_SLOTS timers and handles one item at a time;
// in_ch.ready is high only while the block is idle, and a finished result
// waits in an output register while the next item is taken. Every item
// starts with one pass over the slot memory, one slot per cycle through its
// single registered read port. Add, remove and a query that needs no divide
// then emit their result. A query for a future deadline first runs the
// division by 1000 as a multiply by a fixed reciprocal, built from four
// partial products. A schedule repeats the pass once per fired timer (up to
// 16 per item, earliest deadline first, equal deadlines in slot order), and
// a periodic fire goes through the re-arm adders before the next pass.
// Each fired timer's result is released only once the next pass shows
// whether it is the item's last, or once the sixteenth fire ends the item.
// Slot contents have no reset; a slot's valid flag clears at reset.
module deadline_timer_table #(
  parameter int TIMER_SLOTS = 16
) (
  input logic  clk,
  input logic  rst_n,
  dtt_in_if.sink    in_ch,
  dtt_out_if.source out_ch
);
  import dtt_pkg::*;

  dtt_cmd_t cmd;
  dtt_sts_t sts;

  // Sequencer: decides what the datapath does each cycle.
  dtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: slot storage, the scan compare, arithmetic and the result register.
  dtt_dp #(.N(TIMER_SLOTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_ch.opcode),
    .in_now_us       (in_ch.now_us),
    .in_delay_us     (in_ch.delay_us),
    .in_periodic     (in_ch.periodic),
    .in_target_id    (in_ch.target_id),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_timer_ident (out_ch.timer_ident),
    .out_wait_ms     (out_ch.wait_ms),
    .out_last        (out_ch.last)
  );

endmodule
